>>> src/sinr_link_set_feasibility_check_top_defines.svh
// Assertion helpers for the link set feasibility checker.
`ifndef SINR_LINK_SET_FEASIBILITY_CHECK_TOP_DEFINES_SVH
`define SINR_LINK_SET_FEASIBILITY_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define SLFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slfc: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define SLFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slfc: next-cycle check failed");

`endif

>>> src/slfc_pkg.sv
`default_nettype none
package slfc_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_LINKS_DEF = 32;
    localparam int NODE_FW       = 6;
    localparam int POWER_W       = 48;
    localparam int THRESH_W      = 32;
    localparam int NODE_SLOTS    = 64;
    localparam int FIFO_DEPTH    = 2;
    localparam int STAT_CNT_W    = 8;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd655360;

    // Command class of one queued word
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_LINK,
        CMD_CHECK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [NODE_FW-1:0]   tx;
        logic [NODE_FW-1:0]   rx;
        logic [POWER_W-1:0]   power;
    } cmd_t;

    // Check engine sequencer
    typedef enum logic [4:0] {
        B_IDLE,
        B_START,
        B_LINK_RD,
        B_LINK_GOT,
        B_M_RD,
        B_M_GOT,
        B_M_PW,
        B_M_DEN,
        B_SELF_RD,
        B_SELF_GOT,
        B_MUL0,
        B_MUL1,
        B_CMP,
        B_PLACE,
        B_PL_RD,
        B_PL_WR,
        B_NEXT,
        B_RESULT
    } back_state_t;

    typedef struct packed {
        logic                  checking;
        logic [STAT_CNT_W-1:0] link_cnt;
    } back_stat_t;

endpackage
`default_nettype wire

>>> src/slfc_front.sv
`default_nettype none
module slfc_front (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         item_valid,
    output logic                        item_ready,
    input  wire                         kind,
    input  wire  [slfc_pkg::NODE_FW-1:0] tx_node,
    input  wire  [slfc_pkg::NODE_FW-1:0] rx_node,
    input  wire  [slfc_pkg::POWER_W-1:0] power,
    input  wire                         last,
    output logic                        push_valid,
    output slfc_pkg::cmd_t              push_cmd,
    input  wire                         push_ready
);
    import slfc_pkg::*;

    logic hold_valid_reg;
    cmd_t hold_cmd_reg;
    cmd_t cls_cmd;

    // Classify the incoming word; the last mark only counts on a link
    always_comb
    begin
        cls_cmd.tx    = tx_node;
        cls_cmd.rx    = rx_node;
        cls_cmd.power = power;
        if (!kind)
            cls_cmd.op = CMD_LOAD;
        else if (last)
            cls_cmd.op = CMD_CHECK;
        else
            cls_cmd.op = CMD_LINK;
    end

    assign item_ready = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (item_ready)
            hold_valid_reg <= item_valid;
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            hold_cmd_reg <= cls_cmd;
    end

endmodule
`default_nettype wire

>>> src/slfc_queue.sv
`default_nettype none
module slfc_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push_valid,
    output logic           push_ready,
    input  slfc_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  wire            pop_ready,
    output slfc_pkg::cmd_t pop_cmd
);
    import slfc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             slot_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = fill_reg != CNT_W'(FIFO_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_mem[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

>>> src/slfc_back.sv
`default_nettype none
module slfc_back #(
    parameter int MAX_NODES = slfc_pkg::MAX_NODES_DEF,
    parameter int MAX_LINKS = slfc_pkg::MAX_LINKS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  [slfc_pkg::THRESH_W-1:0] thresh,
    input  wire                           pop_valid,
    output logic                          pop_ready,
    input  slfc_pkg::cmd_t                pop_cmd,
    output logic                          result_valid,
    input  wire                           result_ready,
    output logic                          feasible,
    output slfc_pkg::back_stat_t          stat
);
    import slfc_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int XW     = (NW > NODE_FW) ? NW : NODE_FW;
    localparam int TDEPTH = MAX_NODES * MAX_NODES;
    localparam int AW     = $clog2(TDEPTH);
    localparam int LW     = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CW     = $clog2(MAX_LINKS + 1);
    localparam int IW     = POWER_W + CW;
    localparam int DW     = IW + 1;
    localparam int DHW    = DW - 32;
    localparam int PW     = THRESH_W + DW;
    localparam int LKW    = 2 * NODE_FW;

    back_state_t state_reg, state_next;

    // Memories and their read registers
    logic [POWER_W-1:0] power_table [TDEPTH];
    logic [IW-1:0]      intf_mem    [MAX_NODES];
    logic [LKW-1:0]     link_mem    [MAX_LINKS];
    logic [POWER_W-1:0] tbl_rd_reg;
    logic               tbl_zero_reg;
    logic [IW-1:0]      intf_rd_reg;
    logic               intf_zero_reg;
    logic [LKW-1:0]     link_rd_reg;

    // Control state
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         k_reg;
    logic [CW-1:0]         m_reg;
    logic [NW-1:0]         n_reg;
    logic [NODE_SLOTS-1:0] busy_reg;
    logic [MAX_NODES-1:0]  ivalid_reg;
    logic                  self_phase_reg;
    logic                  ok_reg;
    logic                  result_valid_reg;
    logic                  feasible_reg;

    // Payload state
    logic [NODE_FW-1:0]        s_reg;
    logic [NODE_FW-1:0]        r_reg;
    logic [NODE_FW-1:0]        pr_reg;
    logic [POWER_W-1:0]        num_reg;
    logic [DW-1:0]             den_reg;
    logic [63:0]               p0_reg;
    logic [THRESH_W+DHW-1:0]   p1_reg;

    // Combinational control
    logic [XW-1:0]  rd_tx;
    logic [XW-1:0]  rd_rx;
    logic [XW-1:0]  rd_intf;
    logic [LW-1:0]  link_addr;
    logic           tbl_zero;
    logic           intf_zero;
    logic [AW-1:0]  tbl_rd_addr;
    logic [AW-1:0]  tbl_wr_addr;
    logic           tbl_we;
    logic           link_we;
    logic           intf_we;
    logic           take_result;
    logic           wr_in_range;
    logic [POWER_W-1:0] pw_val;
    logic [IW-1:0]      intf_val;
    logic [PW-1:0]      prod;
    logic               below;
    logic               link_busy;
    logic               s_in_range;
    logic               n_is_end;
    logic               n_is_endpoint;

    assign pw_val   = tbl_zero_reg ? '0 : tbl_rd_reg;
    assign intf_val = intf_zero_reg ? '0 : intf_rd_reg;

    // Threshold times denominator against the numerator scaled by 2^16
    assign prod  = PW'(p0_reg) + (PW'(p1_reg) << 32);
    assign below = prod > PW'({num_reg, 16'b0});

    assign link_busy = busy_reg[link_rd_reg[LKW-1:NODE_FW]]
                    || busy_reg[link_rd_reg[NODE_FW-1:0]];
    assign s_in_range    = {1'b0, XW'(s_reg)} < (XW+1)'(MAX_NODES);
    assign n_is_end      = n_reg == NW'(MAX_NODES - 1);
    assign n_is_endpoint = (XW'(n_reg) == XW'(s_reg)) || (XW'(n_reg) == XW'(r_reg));
    assign take_result   = !result_valid_reg || result_ready;

    assign wr_in_range = ({1'b0, XW'(pop_cmd.tx)} < (XW+1)'(MAX_NODES))
                      && ({1'b0, XW'(pop_cmd.rx)} < (XW+1)'(MAX_NODES));
    assign tbl_wr_addr = AW'(pop_cmd.tx) * AW'(MAX_NODES) + AW'(pop_cmd.rx);

    // Select read addresses and write enables for the current step
    always_comb
    begin
        rd_tx     = XW'(s_reg);
        rd_rx     = XW'(n_reg);
        rd_intf   = XW'(n_reg);
        link_addr = k_reg[LW-1:0];
        pop_ready = 1'b0;
        tbl_we    = 1'b0;
        link_we   = 1'b0;
        intf_we   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                tbl_we    = pop_valid && (pop_cmd.op == CMD_LOAD) && wr_in_range;
                link_we   = pop_valid && (pop_cmd.op != CMD_LOAD)
                         && (cnt_reg < CW'(MAX_LINKS));
            end
            B_M_RD:
                link_addr = m_reg[LW-1:0];
            B_M_GOT:
            begin
                rd_tx   = XW'(link_rd_reg[LKW-1:NODE_FW]);
                rd_rx   = XW'(link_rd_reg[NODE_FW-1:0]);
                rd_intf = XW'(link_rd_reg[NODE_FW-1:0]);
            end
            B_M_PW:
                rd_rx = XW'(pr_reg);
            B_SELF_RD:
            begin
                rd_rx   = XW'(r_reg);
                rd_intf = XW'(r_reg);
            end
            B_PL_WR:
                intf_we = !n_is_endpoint;
            default:
            begin
            end
        endcase
    end

    assign tbl_zero  = !(({1'b0, rd_tx} < (XW+1)'(MAX_NODES))
                      && ({1'b0, rd_rx} < (XW+1)'(MAX_NODES)));
    assign intf_zero = !({1'b0, rd_intf} < (XW+1)'(MAX_NODES))
                    || !ivalid_reg[rd_intf[NW-1:0]];
    assign tbl_rd_addr = AW'(rd_tx[NW-1:0]) * AW'(MAX_NODES) + AW'(rd_rx[NW-1:0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (pop_valid && (pop_cmd.op == CMD_CHECK))
                    state_next = B_START;
            B_START:
                state_next = (cnt_reg == '0) ? B_RESULT : B_LINK_RD;
            B_LINK_RD:
                state_next = B_LINK_GOT;
            B_LINK_GOT:
                if (k_reg == '0)
                    state_next = B_PLACE;
                else if (link_busy)
                    state_next = B_RESULT;
                else
                    state_next = B_M_RD;
            B_M_RD:
                state_next = B_M_GOT;
            B_M_GOT:
                state_next = B_M_PW;
            B_M_PW:
                state_next = B_M_DEN;
            B_M_DEN:
                state_next = B_MUL0;
            B_SELF_RD:
                state_next = B_SELF_GOT;
            B_SELF_GOT:
                state_next = B_MUL0;
            B_MUL0:
                state_next = B_MUL1;
            B_MUL1:
                state_next = B_CMP;
            B_CMP:
                if (below)
                    state_next = B_RESULT;
                else if (self_phase_reg)
                    state_next = B_PLACE;
                else if ((m_reg + CW'(1)) == k_reg)
                    state_next = B_SELF_RD;
                else
                    state_next = B_M_RD;
            B_PLACE:
                state_next = s_in_range ? B_PL_RD : B_NEXT;
            B_PL_RD:
                state_next = B_PL_WR;
            B_PL_WR:
                state_next = n_is_end ? B_NEXT : B_PL_RD;
            B_NEXT:
                state_next = ((k_reg + CW'(1)) == cnt_reg) ? B_RESULT : B_LINK_RD;
            B_RESULT:
                if (take_result)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            cnt_reg          <= '0;
            k_reg            <= '0;
            m_reg            <= '0;
            n_reg            <= '0;
            busy_reg         <= '0;
            ivalid_reg       <= '0;
            self_phase_reg   <= 1'b0;
            ok_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            feasible_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (link_we)
                cnt_reg <= cnt_reg + CW'(1);
            if (result_valid_reg && result_ready && (state_reg != B_RESULT))
                result_valid_reg <= 1'b0;
            unique case (state_reg)
                B_START:
                begin
                    busy_reg   <= '0;
                    ivalid_reg <= '0;
                    k_reg      <= '0;
                    ok_reg     <= 1'b1;
                end
                B_LINK_GOT:
                begin
                    m_reg <= '0;
                    if (k_reg != '0 && link_busy)
                        ok_reg <= 1'b0;
                end
                B_M_DEN:
                    self_phase_reg <= 1'b0;
                B_SELF_GOT:
                    self_phase_reg <= 1'b1;
                B_CMP:
                    if (below)
                        ok_reg <= 1'b0;
                    else if (!self_phase_reg)
                        m_reg <= m_reg + CW'(1);
                B_PLACE:
                begin
                    busy_reg <= busy_reg | (NODE_SLOTS'(1) << s_reg)
                                         | (NODE_SLOTS'(1) << r_reg);
                    n_reg    <= '0;
                end
                B_PL_WR:
                begin
                    if (intf_we)
                        ivalid_reg[n_reg] <= 1'b1;
                    if (!n_is_end)
                        n_reg <= n_reg + NW'(1);
                end
                B_NEXT:
                    k_reg <= k_reg + CW'(1);
                B_RESULT:
                    if (take_result)
                    begin
                        result_valid_reg <= 1'b1;
                        feasible_reg     <= ok_reg;
                        cnt_reg          <= '0;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers and multiplier halves
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_LINK_GOT:
            begin
                s_reg <= link_rd_reg[LKW-1:NODE_FW];
                r_reg <= link_rd_reg[NODE_FW-1:0];
            end
            B_M_GOT:
                pr_reg <= link_rd_reg[NODE_FW-1:0];
            B_M_PW:
            begin
                num_reg <= pw_val;
                den_reg <= DW'(intf_val);
            end
            B_M_DEN:
                den_reg <= den_reg + DW'(pw_val);
            B_SELF_GOT:
            begin
                num_reg <= pw_val;
                den_reg <= DW'(intf_val);
            end
            B_MUL0:
                p0_reg <= 64'(thresh) * 64'(den_reg[31:0]);
            B_MUL1:
                p1_reg <= (THRESH_W+DHW)'(thresh) * (THRESH_W+DHW)'(den_reg[DW-1:32]);
            default:
            begin
            end
        endcase
    end

    // Power table port
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            power_table[tbl_wr_addr] <= pop_cmd.power;
        tbl_rd_reg   <= power_table[tbl_rd_addr];
        tbl_zero_reg <= tbl_zero;
    end

    // Interference port
    always_ff @(posedge clk)
    begin
        if (intf_we)
            intf_mem[n_reg] <= intf_val + IW'(pw_val);
        intf_rd_reg   <= intf_mem[rd_intf[NW-1:0]];
        intf_zero_reg <= intf_zero;
    end

    // Link list port
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[cnt_reg[LW-1:0]] <= {pop_cmd.tx, pop_cmd.rx};
        link_rd_reg <= link_mem[link_addr];
    end

    assign result_valid  = result_valid_reg;
    assign feasible      = feasible_reg;
    assign stat.checking = state_reg != B_IDLE;
    assign stat.link_cnt = STAT_CNT_W'(cnt_reg);

endmodule
`default_nettype wire

>>> src/sinr_link_set_feasibility_check_top.sv
// Table loads and link words: one word per cycle while the queue has room, through the front
// hold register and a queue slot. A word marked last runs the check: each link k >= 1 is tested
// against every earlier link and itself, then each link updates all MAX_NODES nodes, bounded by
// the single power-table read port; input stalls meanwhile. An output register holds the result.
// Reset clears control, the link count and sets the threshold to 10.0; the table is not cleared.
`default_nettype none
`include "sinr_link_set_feasibility_check_top_defines.svh"
module sinr_link_set_feasibility_check_top #(
    parameter int MAX_NODES = slfc_pkg::MAX_NODES_DEF,
    parameter int MAX_LINKS = slfc_pkg::MAX_LINKS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wr_en,
    input  wire  [slfc_pkg::THRESH_W-1:0] cfg_wr_data,
    input  wire                           item_valid,
    output logic                          item_ready,
    input  wire                           kind,
    input  wire  [slfc_pkg::NODE_FW-1:0]  tx_node,
    input  wire  [slfc_pkg::NODE_FW-1:0]  rx_node,
    input  wire  [slfc_pkg::POWER_W-1:0]  power,
    input  wire                           last,
    output logic                          result_valid,
    input  wire                           result_ready,
    output logic                          feasible
);
    import slfc_pkg::*;

    logic [THRESH_W-1:0] thresh_reg;
    logic                push_valid;
    logic                push_ready;
    cmd_t                push_cmd;
    logic                pop_valid;
    logic                pop_ready;
    cmd_t                pop_cmd;
    back_stat_t          back_stat;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_RESET;
        else if (cfg_wr_en)
            thresh_reg <= cfg_wr_data;
    end

    slfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .kind       (kind),
        .tx_node    (tx_node),
        .rx_node    (rx_node),
        .power      (power),
        .last       (last),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    slfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    slfc_back #(
        .MAX_NODES (MAX_NODES),
        .MAX_LINKS (MAX_LINKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .thresh       (thresh_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .feasible     (feasible),
        .stat         (back_stat)
    );

    // Link count never exceeds the list depth
    `SLFC_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, back_stat.link_cnt <= STAT_CNT_W'(MAX_LINKS))
    // A fresh result only follows a running check
    `SLFC_ASSERT_NOW(a_result_from_check, clk, rst_n, $rose(result_valid), $past(back_stat.checking))
    // Delivering a result empties the link list
    `SLFC_ASSERT_NOW(a_list_cleared, clk, rst_n, $rose(result_valid), back_stat.link_cnt == '0)
    // An empty idle list grows by at most one link per cycle
    `SLFC_ASSERT_NEXT(a_cnt_step, clk, rst_n, !back_stat.checking && back_stat.link_cnt == '0, back_stat.link_cnt <= STAT_CNT_W'(1))

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slfc_pkg::*;

    localparam bit KIND_LOAD = 1'b0;
    localparam bit KIND_LINK = 1'b1;
    localparam int NODES = 64;
    localparam int LINKS = 32;
    localparam int EXP_PREDICT = 2;
    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [THRESH_W-1:0] cfg_wr_data;
    logic                item_valid;
    logic                item_ready;
    logic                kind;
    logic [NODE_FW-1:0]  tx_node;
    logic [NODE_FW-1:0]  rx_node;
    logic [POWER_W-1:0]  power;
    logic                last;
    logic                result_valid;
    logic                result_ready;
    logic                feasible;

    sinr_link_set_feasibility_check_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .item_valid(item_valid), .item_ready(item_ready),
        .kind(kind), .tx_node(tx_node), .rx_node(rx_node), .power(power), .last(last),
        .result_valid(result_valid), .result_ready(result_ready), .feasible(feasible)
    );

    // Mirror of the block state
    logic [POWER_W-1:0]  gain_tbl [NODES][NODES];
    logic [NODE_FW-1:0]  set_tx [LINKS];
    logic [NODE_FW-1:0]  set_rx [LINKS];
    int                  set_len;
    logic [THRESH_W-1:0] sinr_min;

    bit   feasible_q [$];
    int   errors;
    int   words_sent;
    int   checks_done;
    int   feasible_seen;
    int   thresholds_used;
    bit   calm;

    // Senders whose whole power row is loaded; bits of each position take both values
    logic [NODE_FW-1:0] senders [6] = '{6'd0, 6'd63, 6'd21, 6'd42, 6'd15, 6'd48};

    typedef struct {
        bit                 k;
        logic [NODE_FW-1:0] t;
        logic [NODE_FW-1:0] r;
        logic [POWER_W-1:0] p;
        bit                 l;
        int                 exp_val;
    } stim_row_t;

    stim_row_t directed [] = '{
        '{KIND_LOAD, 6'd0,  6'd0,  '0,        1'b1, EXP_PREDICT},
        '{KIND_LOAD, 6'd63, 6'd63, POWER_MAX, 1'b0, EXP_PREDICT},
        '{KIND_LINK, 6'd63, 6'd63, '0,        1'b1, 1},
        '{KIND_LINK, 6'd0,  6'd5,  '0,        1'b0, EXP_PREDICT},
        '{KIND_LINK, 6'd0,  6'd5,  '0,        1'b1, 0},
        '{KIND_LINK, 6'd0,  6'd1,  '0,        1'b0, EXP_PREDICT},
        '{KIND_LINK, 6'd15, 6'd1,  '0,        1'b1, 0},
        '{KIND_LOAD, 6'd21, 6'd7,  POWER_MAX, 1'b0, EXP_PREDICT},
        '{KIND_LOAD, 6'd42, 6'd9,  POWER_MAX, 1'b0, EXP_PREDICT},
        '{KIND_LOAD, 6'd21, 6'd9,  48'd1,     1'b0, EXP_PREDICT},
        '{KIND_LOAD, 6'd42, 6'd7,  48'd1,     1'b0, EXP_PREDICT},
        '{KIND_LINK, 6'd21, 6'd7,  POWER_MAX, 1'b0, EXP_PREDICT},
        '{KIND_LINK, 6'd42, 6'd9,  '0,        1'b1, EXP_PREDICT},
        '{KIND_LINK, 6'd15, 6'd11, '0,        1'b0, EXP_PREDICT},
        '{KIND_LINK, 6'd48, 6'd20, '0,        1'b0, EXP_PREDICT},
        '{KIND_LINK, 6'd0,  6'd30, '0,        1'b1, EXP_PREDICT}
    };

    // True when num / den falls below the threshold, done as a widened product
    function automatic bit sinr_short(logic [POWER_W-1:0] num, logic [63:0] den);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = 128'(sinr_min) * 128'(den);
        rhs = {64'b0, num, 16'b0};
        return lhs > rhs;
    endfunction

    // Walk the stored links in order and decide feasibility of the set
    function automatic bit link_set_ok();
        logic [63:0]        interf [NODES];
        bit                 busy [NODES];
        logic [NODE_FW-1:0] s;
        logic [NODE_FW-1:0] r;
        logic [NODE_FW-1:0] pr;
        for (int n = 0; n < NODES; n++)
        begin
            interf[n] = '0;
            busy[n] = 1'b0;
        end
        if (set_len == 0)
            return 1'b1;
        for (int k = 0; k < set_len; k++)
        begin
            s = set_tx[k];
            r = set_rx[k];
            if (k > 0)
            begin
                if (busy[s] || busy[r])
                    return 1'b0;
                for (int m = 0; m < k; m++)
                begin
                    pr = set_rx[m];
                    if (sinr_short(gain_tbl[set_tx[m]][pr], interf[pr] + 64'(gain_tbl[s][pr])))
                        return 1'b0;
                end
                if (sinr_short(gain_tbl[s][r], interf[r]))
                    return 1'b0;
            end
            busy[s] = 1'b1;
            busy[r] = 1'b1;
            for (int n = 0; n < NODES; n++)
                if (n != s && n != r)
                    interf[n] += 64'(gain_tbl[s][n]);
        end
        return 1'b1;
    endfunction

    // Update the mirror for one accepted word; returns 0, 1 or EXP_PREDICT for no result
    function automatic int apply_word(bit k, logic [NODE_FW-1:0] t, logic [NODE_FW-1:0] r,
                                      logic [POWER_W-1:0] p, bit l);
        bit ok;
        if (k == KIND_LOAD)
        begin
            gain_tbl[t][r] = p;
            return EXP_PREDICT;
        end
        if (set_len < LINKS)
        begin
            set_tx[set_len] = t;
            set_rx[set_len] = r;
            set_len++;
        end
        if (!l)
            return EXP_PREDICT;
        ok = link_set_ok();
        set_len = 0;
        return int'(ok);
    endfunction

    function automatic logic [POWER_W-1:0] rand_power();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return POWER_W'(raw >> $urandom_range(0, 50));
    endfunction

    // Drive one word and hold it until accepted
    task automatic send_word(bit k, logic [NODE_FW-1:0] t, logic [NODE_FW-1:0] r,
                             logic [POWER_W-1:0] p, bit l, int typed);
        int  gap;
        int  got;
        bit  rdy;
        gap = (!calm && $urandom_range(99) < 16) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= k;
        tx_node <= t;
        rx_node <= r;
        power <= p;
        last <= l;
        do
        begin
            @(negedge clk);
            rdy = item_ready;
            @(posedge clk);
        end
        while (!rdy);
        words_sent++;
        got = apply_word(k, t, r, p, l);
        if (got != EXP_PREDICT)
        begin
            checks_done++;
            feasible_q.push_back(typed != EXP_PREDICT ? typed[0] : got[0]);
        end
    endtask

    // Hold off until every result is back, then let the block settle
    task automatic drain();
        if (item_valid)
            item_valid <= 1'b0;
        while (feasible_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_threshold(logic [THRESH_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sinr_min = v;
        thresholds_used++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random backpressure on results, off during calm stretches
    always @(posedge clk)
        result_ready <= calm || ($urandom_range(99) >= 24);

    // Compare each accepted result word with the oldest expectation
    always @(negedge clk)
    begin
        bit want;
        if (rst_n && result_valid && result_ready)
        begin
            if (feasible_q.size() == 0)
            begin
                $error("unexpected result word: feasible=%0b", feasible);
                errors++;
            end
            else
            begin
                want = feasible_q.pop_front();
                if (feasible !== want)
                begin
                    $error("feasible mismatch: expected %0b, actual %0b", want, feasible);
                    errors++;
                end
                if (feasible === 1'b1)
                    feasible_seen++;
            end
        end
    end

    initial
    begin
        #50ms;
        $display("[sinr_link_set_feasibility_check_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [THRESH_W-1:0] phase_thr [5];
        int phase_words;
        int len;
        int s_idx;
        logic [NODE_FW-1:0] prev_t;
        logic [NODE_FW-1:0] prev_r;
        errors = 0;
        words_sent = 0;
        checks_done = 0;
        feasible_seen = 0;
        thresholds_used = 0;
        calm = 1'b0;
        set_len = 0;
        sinr_min = THRESH_RESET;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        item_valid = 1'b0;
        kind = KIND_LOAD;
        tx_node = '0;
        rx_node = '0;
        power = '0;
        last = 1'b0;
        result_ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Load full rows for every sender so no check reads an unwritten entry
        calm = 1'b1;
        foreach (senders[i])
            for (int n = 0; n < NODES; n++)
                send_word(KIND_LOAD, senders[i], n[NODE_FW-1:0], rand_power(), 1'b0, EXP_PREDICT);
        calm = 1'b0;

        // Directed words at the reset threshold
        foreach (directed[i])
            send_word(directed[i].k, directed[i].t, directed[i].r, directed[i].p,
                      directed[i].l, directed[i].exp_val);

        phase_thr = '{32'hFFFF_FFFF, 32'h0, THRESH_RESET, $urandom, 32'h0001_0000};
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            set_threshold(phase_thr[ph]);
            calm = (ph == 2);
            phase_words = 0;
            while (phase_words < 40)
            begin
                if ($urandom_range(99) < 20)
                begin
                    // Refresh one table entry in a loaded row
                    send_word(KIND_LOAD, senders[$urandom_range(0, 5)], NODE_FW'($urandom),
                              rand_power(), 1'($urandom), EXP_PREDICT);
                    phase_words++;
                end
                else
                begin
                    len = ($urandom_range(99) < 6) ? $urandom_range(30, 36)
                                                   : $urandom_range(1, 5);
                    for (int k = 0; k < len; k++)
                    begin
                        s_idx = $urandom_range(0, 5);
                        // Now and then repeat the previous link
                        if (k > 0 && $urandom_range(99) < 10)
                            send_word(KIND_LINK, prev_t, prev_r, rand_power(),
                                      k == len - 1, EXP_PREDICT);
                        else
                        begin
                            prev_t = senders[s_idx];
                            prev_r = NODE_FW'($urandom);
                            send_word(KIND_LINK, prev_t, prev_r, rand_power(),
                                      k == len - 1, EXP_PREDICT);
                        end
                        phase_words++;
                    end
                    if ($urandom_range(99) < 5)
                        drain();
                end
            end
        end

        drain();
        repeat (200) @(posedge clk);
        $display("Sent %0d words, checked %0d link sets (%0d feasible) under %0d thresholds",
                 words_sent, checks_done, feasible_seen, thresholds_used);
        if (errors == 0 && feasible_q.size() == 0)
            $display("[sinr_link_set_feasibility_check_top] OK");
        else
            $display("[sinr_link_set_feasibility_check_top] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
